[hw/rtl/sorted_table_insert_search_delete_defines.svh]
// assertion macros shared by the rtl files
`ifndef SORTED_TABLE_INSERT_SEARCH_DELETE_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_DELETE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define STI_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("sorted table assertion failed");
// consequent must hold in the cycle after the antecedent
`define STI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted table assertion failed");
`else
`define STI_ASSERT(label, clk, rstn, prop)
`define STI_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/sti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sti_pkg;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_FULL      = 3'd1,
        STS_FOUND     = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_DELETED   = 3'd4,
        STS_EMPTY     = 3'd5
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESOLVE,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_DN_RD,
        S_DN_WR,
        S_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    cap;
        logic    scan_rd;
        logic    scan_step;
        logic    set_pos;
        logic    init_up;
        logic    up_rd;
        logic    up_wr;
        logic    ins_wr;
        logic    init_dn;
        logic    dn_rd;
        logic    dn_wr;
        logic    dec;
        logic    set_st;
        status_t st;
        logic    load_out;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic scan_end;
        logic ge;
        logic eq;
        logic hit;
        logic up_done;
        logic dn_done;
        logic out_busy;
    } dp_sts_t;

endpackage
`default_nettype wire

[hw/rtl/sti_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/sti_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_insert_search_delete_defines.svh"
module sti_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sti_pkg::dp_cmd_t   cmd,
    output sti_pkg::dp_sts_t        sts,
    input  wire logic [31:0]        s_tdata,
    input  wire logic [1:0]         s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    sti_pkg::op_t       op_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg;
    logic               hit_reg;
    sti_pkg::status_t   st_reg;
    logic               out_valid_reg;
    sti_pkg::status_t   out_status_reg;
    logic [4:0]         out_count_reg;

    logic [CW-1:0]      idx_m1, idx_p1;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [31:0]        ram_wdata, ram_rdata;

    assign idx_m1 = idx_reg - CW'(1);
    assign idx_p1 = idx_reg + CW'(1);

    // ram address and data selection
    always_comb begin
        ram_raddr = idx_reg[AW-1:0];
        if (cmd.up_rd) begin
            ram_raddr = idx_m1[AW-1:0];
        end else if (cmd.dn_rd) begin
            ram_raddr = idx_p1[AW-1:0];
        end else if (cmd.scan_rd) begin
            ram_raddr = idx_reg[AW-1:0];
        end
        ram_we    = cmd.up_wr | cmd.dn_wr | cmd.ins_wr;
        ram_waddr = cmd.ins_wr ? pos_reg[AW-1:0] : idx_reg[AW-1:0];
        ram_wdata = cmd.ins_wr ? value_reg : ram_rdata;
    end

    sti_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // status toward the controller
    always_comb begin
        sts.op       = op_reg;
        sts.full     = occ_reg >= CW'(CAPACITY);
        sts.empty    = occ_reg == '0;
        sts.scan_end = idx_reg >= occ_reg;
        sts.ge       = $signed(ram_rdata) >= value_reg;
        sts.eq       = ram_rdata == value_reg;
        sts.hit      = hit_reg;
        sts.up_done  = idx_reg == pos_reg;
        sts.dn_done  = idx_p1 >= occ_reg;
        sts.out_busy = out_valid_reg & ~m_tready;
    end

    // index and occupancy updates
    always_comb begin
        idx_next = idx_reg;
        if (cmd.cap) begin
            idx_next = '0;
        end else if (cmd.scan_step || cmd.dn_wr) begin
            idx_next = idx_p1;
        end else if (cmd.up_wr) begin
            idx_next = idx_m1;
        end else if (cmd.init_up) begin
            idx_next = occ_reg;
        end else if (cmd.init_dn) begin
            idx_next = pos_reg;
        end
        occ_next = occ_reg;
        if (cmd.ins_wr) begin
            occ_next = occ_reg + CW'(1);
        end else if (cmd.dec) begin
            occ_next = occ_reg - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.cap) begin
            op_reg    <= sti_pkg::op_t'(s_tuser);
            value_reg <= s_tdata;
        end
        if (cmd.set_pos) begin
            pos_reg <= idx_reg;
            hit_reg <= sts.eq & ~sts.scan_end;
        end
        if (cmd.set_st) begin
            st_reg <= cmd.st;
        end
        if (cmd.load_out) begin
            out_status_reg <= st_reg;
            out_count_reg  <= 5'(occ_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_status_reg};

    `STI_ASSERT(a_occ_bound, aclk, aresetn, occ_reg <= CW'(CAPACITY))
    `STI_ASSERT(a_no_ins_full, aclk, aresetn, !(cmd.ins_wr && occ_reg >= CW'(CAPACITY)))
    `STI_ASSERT_NEXT(a_load_holds, aclk, aresetn, cmd.load_out, m_tvalid)

endmodule
`default_nettype wire

[hw/rtl/sti_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_insert_search_delete_defines.svh"
module sti_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire sti_pkg::dp_sts_t sts,
    output sti_pkg::dp_cmd_t      cmd
);

    sti_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sti_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.st     = sti_pkg::STS_NOT_FOUND;
        s_tready   = 1'b0;
        case (state_reg)
            sti_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = sti_pkg::S_DECODE;
                end
            end
            sti_pkg::S_DECODE: begin
                case (sts.op)
                    sti_pkg::OP_INSERT: begin
                        if (sts.full) begin
                            cmd.set_st = 1'b1;
                            cmd.st     = sti_pkg::STS_FULL;
                            state_next = sti_pkg::S_FINISH;
                        end else begin
                            state_next = sti_pkg::S_SCAN_RD;
                        end
                    end
                    sti_pkg::OP_SEARCH: begin
                        state_next = sti_pkg::S_SCAN_RD;
                    end
                    sti_pkg::OP_DELETE: begin
                        if (sts.empty) begin
                            cmd.set_st = 1'b1;
                            cmd.st     = sti_pkg::STS_EMPTY;
                            state_next = sti_pkg::S_FINISH;
                        end else begin
                            state_next = sti_pkg::S_SCAN_RD;
                        end
                    end
                    default: begin
                        cmd.set_st = 1'b1;
                        cmd.st     = sti_pkg::STS_NOT_FOUND;
                        state_next = sti_pkg::S_FINISH;
                    end
                endcase
            end
            // walk up to the first entry not below the value
            sti_pkg::S_SCAN_RD: begin
                if (sts.scan_end) begin
                    cmd.set_pos = 1'b1;
                    state_next  = sti_pkg::S_RESOLVE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = sti_pkg::S_SCAN_CMP;
                end
            end
            sti_pkg::S_SCAN_CMP: begin
                if (sts.ge) begin
                    cmd.set_pos = 1'b1;
                    state_next  = sti_pkg::S_RESOLVE;
                end else begin
                    cmd.scan_step = 1'b1;
                    state_next    = sti_pkg::S_SCAN_RD;
                end
            end
            sti_pkg::S_RESOLVE: begin
                case (sts.op)
                    sti_pkg::OP_INSERT: begin
                        cmd.init_up = 1'b1;
                        state_next  = sti_pkg::S_UP_RD;
                    end
                    sti_pkg::OP_DELETE: begin
                        if (sts.hit) begin
                            cmd.init_dn = 1'b1;
                            state_next  = sti_pkg::S_DN_RD;
                        end else begin
                            cmd.set_st = 1'b1;
                            cmd.st     = sti_pkg::STS_NOT_FOUND;
                            state_next = sti_pkg::S_FINISH;
                        end
                    end
                    default: begin
                        cmd.set_st = 1'b1;
                        cmd.st     = sts.hit ? sti_pkg::STS_FOUND : sti_pkg::STS_NOT_FOUND;
                        state_next = sti_pkg::S_FINISH;
                    end
                endcase
            end
            // move entries up one slot, top first
            sti_pkg::S_UP_RD: begin
                if (sts.up_done) begin
                    state_next = sti_pkg::S_INS_WR;
                end else begin
                    cmd.up_rd  = 1'b1;
                    state_next = sti_pkg::S_UP_WR;
                end
            end
            sti_pkg::S_UP_WR: begin
                cmd.up_wr  = 1'b1;
                state_next = sti_pkg::S_UP_RD;
            end
            sti_pkg::S_INS_WR: begin
                cmd.ins_wr = 1'b1;
                cmd.set_st = 1'b1;
                cmd.st     = sti_pkg::STS_INSERTED;
                state_next = sti_pkg::S_FINISH;
            end
            // move entries down one slot over the removed one
            sti_pkg::S_DN_RD: begin
                if (sts.dn_done) begin
                    cmd.dec    = 1'b1;
                    cmd.set_st = 1'b1;
                    cmd.st     = sti_pkg::STS_DELETED;
                    state_next = sti_pkg::S_FINISH;
                end else begin
                    cmd.dn_rd  = 1'b1;
                    state_next = sti_pkg::S_DN_WR;
                end
            end
            sti_pkg::S_DN_WR: begin
                cmd.dn_wr  = 1'b1;
                state_next = sti_pkg::S_DN_RD;
            end
            sti_pkg::S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = sti_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sti_pkg::S_IDLE;
            end
        endcase
    end

    `STI_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_tvalid && s_tready,
                     state_reg == sti_pkg::S_DECODE)
    `STI_ASSERT(a_one_write, aclk, aresetn,
                $countones({cmd.up_wr, cmd.dn_wr, cmd.ins_wr}) <= 1)
    `STI_ASSERT_NEXT(a_finish_waits, aclk, aresetn,
                     state_reg == sti_pkg::S_FINISH && sts.out_busy,
                     state_reg == sti_pkg::S_FINISH)

endmodule
`default_nettype wire

[hw/rtl/sorted_table_insert_search_delete.sv]
// a full insert, an empty delete or an unused opcode goes from decode straight to the finish
// state; other items first scan the table, then an insert or a found delete moves entries
// a new item is accepted only in the idle state, once the previous result has been loaded out
// a finished result waits in an output register while the next item is accepted
// reset (aresetn low, synchronous) empties the table; no memory clearing pass
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_insert_search_delete #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [2:0] status, [7:3] entry_count
);

    sti_pkg::dp_cmd_t cmd;
    sti_pkg::dp_sts_t sts;

    sti_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sti_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire
